[rtl/status_led_pattern_sequencer_defines.svh]
// Assertion macros used by the checker file of the LED pattern sequencer.
`ifndef STATUS_LED_PATTERN_SEQUENCER_DEFINES_SVH
`define STATUS_LED_PATTERN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define SLPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slps check failed: same-cycle implication");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define SLPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slps check failed: next-cycle implication");

`endif

[rtl/slps_pkg.sv]
// Types and constants of the status LED pattern sequencer.
`default_nettype none

package slps_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_MODE = 2'd1;
  localparam logic [OP_W-1:0] OP_CONNECT  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SETUP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CONNECTED = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FAULTED   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_MS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS  = 2'd2;

  localparam logic [LEN_W-1:0] LONG_MS_RST  = 16'd1000;
  localparam logic [LEN_W-1:0] SHORT_MS_RST = 16'd250;
  localparam logic [LEN_W-1:0] HOLD_MS_RST  = 16'd100;

  typedef enum logic [2:0] {
    PAT_NONE      = 3'd0,
    PAT_CONNECT   = 3'd1,
    PAT_SETUP     = 3'd2,
    PAT_IDLE      = 3'd3,
    PAT_CONNECTED = 3'd4,
    PAT_FAULTED   = 3'd5,
    PAT_OFF       = 3'd6
  } pattern_t;

  typedef struct packed {
    logic [LEN_W-1:0] long_ms;
    logic [LEN_W-1:0] short_ms;
    logic [LEN_W-1:0] hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [MODE_W-1:0] mode_value;
  } item_t;

endpackage

`default_nettype wire

[rtl/slps_if.sv]
// Valid/ready channel interfaces for the input and result transactions.
`default_nettype none

interface slps_in_if;
  import slps_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [MODE_W-1:0] mode_value;

  modport source (output valid, output op, output mode_value, input ready);
  modport sink   (input valid, input op, input mode_value, output ready);
endinterface

interface slps_out_if;
  logic valid;
  logic ready;
  logic led_on;

  modport source (output valid, output led_on, input ready);
  modport sink   (input valid, input led_on, output ready);
endinterface

`default_nettype wire

[rtl/status_led_pattern_sequencer.sv]
// Top level of the status LED pattern sequencer.
//
//   channel  | direction | payload               | handshake
//   in_ch    | in        | op, mode_value        | valid / ready
//   out_ch   | out       | led_on                | valid / ready
//   cfg_*    | in        | index, 16-bit data    | write enable only
//
// One transaction is accepted per clock while out_ch is not stalled; each gives one result
// through the input register, then the pattern update into the result register.
// The rate is set by the single pass through the pattern state update.
// A stall on out_ch holds the result register and the input register behind it.
// rst_n is synchronous; it empties both registers and restores the reset pattern state.
`default_nettype none

module status_led_pattern_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  slps_in_if.sink                        in_ch,
  slps_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [slps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slps_pkg::LEN_W-1:0]     cfg_wdata
);
  import slps_pkg::*;

  cfg_t  cfg;
  item_t in_item_r, in_item_nxt;
  logic  in_valid_r, in_valid_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  out_led_r, out_led_nxt;
  logic  advance;
  logic  step;
  logic  led_level;
  logic  in_take;

  assign advance = !out_valid_r || out_ch.ready;
  assign step    = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  slps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  slps_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (in_item_r),
    .cfg       (cfg),
    .led_level (led_level)
  );

  always_comb begin
    in_valid_nxt  = in_ch.ready ? in_ch.valid : in_valid_r;
    in_item_nxt   = in_item_r;
    if (in_take) begin
      in_item_nxt.op         = in_ch.op;
      in_item_nxt.mode_value = in_ch.mode_value;
    end
    out_valid_nxt = advance ? in_valid_r : out_valid_r;
    out_led_nxt   = step ? led_level : out_led_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_led_r <= out_led_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.led_on = out_led_r;

endmodule

`default_nettype wire

[rtl/slps_cfg_regs.sv]
// Segment length registers written through the plain configuration port.
`default_nettype none

module slps_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [slps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slps_pkg::LEN_W-1:0]     cfg_wdata,
  output slps_pkg::cfg_t                 cfg
);
  import slps_pkg::*;

  cfg_t regs_r;
  cfg_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_LONG_MS:  regs_nxt.long_ms  = cfg_wdata;
        REG_SHORT_MS: regs_nxt.short_ms = cfg_wdata;
        REG_HOLD_MS:  regs_nxt.hold_ms  = cfg_wdata;
        default:      regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.long_ms  <= LONG_MS_RST;
      regs_r.short_ms <= SHORT_MS_RST;
      regs_r.hold_ms  <= HOLD_MS_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg = regs_r;

endmodule

`default_nettype wire

[rtl/slps_core.sv]
// Pattern state machine: stored requests, segment counter and LED level.
`default_nettype none

module slps_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  slps_pkg::item_t item,
  input  slps_pkg::cfg_t  cfg,
  output logic           led_level
);
  import slps_pkg::*;

  localparam int unsigned IDX_W = 3;
  localparam logic [IDX_W-1:0] FAULT_BLINK_SEGS = 3'd6;

  function automatic pattern_t pattern_for_mode(input logic [MODE_W-1:0] mode);
    pattern_t p;
    case (mode)
      MODE_OFF:       p = PAT_OFF;
      MODE_SETUP:     p = PAT_SETUP;
      MODE_IDLE:      p = PAT_IDLE;
      MODE_CONNECTED: p = PAT_CONNECTED;
      MODE_FAULTED:   p = PAT_FAULTED;
      default:        p = PAT_NONE;
    endcase
    return p;
  endfunction

  function automatic logic [IDX_W-1:0] pattern_length(input pattern_t p);
    logic [IDX_W-1:0] n;
    case (p)
      PAT_CONNECT: n = 3'd4;
      PAT_SETUP:   n = 3'd2;
      PAT_IDLE:    n = 3'd2;
      PAT_FAULTED: n = 3'd7;
      default:     n = 3'd1;
    endcase
    return n;
  endfunction

  logic [MODE_W-1:0] req_mode_r, req_mode_nxt;
  logic              pending_r, pending_nxt;
  pattern_t          pat_r, pat_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]  ticks_r, ticks_nxt;
  logic              led_r, led_nxt;

  pattern_t          cur_pat;
  logic [IDX_W-1:0]  cur_idx;
  logic [LEN_W-1:0]  cur_ticks;
  logic              seg_lvl;
  logic [LEN_W-1:0]  seg_dur;
  logic [LEN_W-1:0]  ticks_inc;
  logic [IDX_W-1:0]  idx_inc;
  logic              seg_end;
  logic              pat_end;
  logic              on_half;

  // With no pattern running, a tick first latches the requests and starts segment 0.
  always_comb begin
    if (pat_r == PAT_NONE) begin
      cur_pat   = pending_r ? PAT_CONNECT : pattern_for_mode(req_mode_r);
      cur_idx   = '0;
      cur_ticks = '0;
    end else begin
      cur_pat   = pat_r;
      cur_idx   = idx_r;
      cur_ticks = ticks_r;
    end
  end

  // Level and length of the current segment.
  always_comb begin
    on_half = ~cur_idx[0];
    case (cur_pat)
      PAT_CONNECT, PAT_IDLE: begin
        seg_lvl = on_half;
        seg_dur = cfg.short_ms;
      end
      PAT_SETUP: begin
        seg_lvl = on_half;
        seg_dur = cfg.long_ms;
      end
      PAT_CONNECTED: begin
        seg_lvl = 1'b1;
        seg_dur = cfg.hold_ms;
      end
      PAT_FAULTED: begin
        if (cur_idx < FAULT_BLINK_SEGS) begin
          seg_lvl = on_half;
          seg_dur = cfg.short_ms;
        end else begin
          seg_lvl = 1'b0;
          seg_dur = cfg.long_ms;
        end
      end
      PAT_OFF: begin
        seg_lvl = 1'b0;
        seg_dur = cfg.hold_ms;
      end
      default: begin
        seg_lvl = led_r;
        seg_dur = {{(LEN_W-1){1'b0}}, 1'b1};
      end
    endcase
  end

  // A zero length register ends the segment after one tick, since every count is at least zero.
  assign ticks_inc = cur_ticks + {{(LEN_W-1){1'b0}}, 1'b1};
  assign idx_inc   = cur_idx + {{(IDX_W-1){1'b0}}, 1'b1};
  assign seg_end   = (ticks_inc >= seg_dur) || (ticks_inc == '0);
  assign pat_end   = idx_inc >= pattern_length(cur_pat);

  always_comb begin
    req_mode_nxt = req_mode_r;
    pending_nxt  = pending_r;
    pat_nxt      = pat_r;
    idx_nxt      = idx_r;
    ticks_nxt    = ticks_r;
    led_nxt      = led_r;
    if (step) begin
      case (item.op)
        OP_TICK: begin
          if (cur_pat != PAT_NONE) begin
            led_nxt = seg_lvl;
            if (!seg_end) begin
              pat_nxt   = cur_pat;
              idx_nxt   = cur_idx;
              ticks_nxt = ticks_inc;
            end else if (!pat_end) begin
              pat_nxt   = cur_pat;
              idx_nxt   = idx_inc;
              ticks_nxt = '0;
            end else begin
              // Finishing the double blink drops every connection signal seen meanwhile.
              if (cur_pat == PAT_CONNECT) begin
                pending_nxt = 1'b0;
              end
              pat_nxt   = PAT_NONE;
              idx_nxt   = '0;
              ticks_nxt = '0;
            end
          end
        end
        OP_SET_MODE: req_mode_nxt = item.mode_value;
        OP_CONNECT:  pending_nxt  = 1'b1;
        default:     req_mode_nxt = req_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_mode_r <= MODE_SETUP;
      pending_r  <= 1'b0;
      pat_r      <= PAT_NONE;
      idx_r      <= '0;
      ticks_r    <= '0;
      led_r      <= 1'b0;
    end else begin
      req_mode_r <= req_mode_nxt;
      pending_r  <= pending_nxt;
      pat_r      <= pat_nxt;
      idx_r      <= idx_nxt;
      ticks_r    <= ticks_nxt;
      led_r      <= led_nxt;
    end
  end

  assign led_level = led_nxt;

endmodule

`default_nettype wire

[rtl/slps_checker.sv]
// Port-level checks on the sequencer's channels, bound to the top level.
`default_nettype none

`include "status_led_pattern_sequencer_defines.svh"

module slps_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic led_on
);

  // A result that is not taken stays offered with the same level.
  `SLPS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(led_on))

  // The input side is never held up while the result side can move.
  `SLPS_ASSERT_IMP(a_in_free, !out_valid || out_ready, in_ready)

  // An accepted transaction reaches the result register once the output can move.
  `SLPS_ASSERT_NXT(a_in_to_out, (in_valid && in_ready) ##1 out_ready, out_valid)

endmodule

bind status_led_pattern_sequencer slps_checker u_slps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .led_on    (out_ch.led_on)
);

`default_nettype wire
